// File: rtl/adler_pkg.sv
// Shared constants, types and modular reduction helpers for the Adler-32 engine.
`timescale 1ns / 1ps

package adler_pkg;

    // Lane count default and the widths that the stream fields fix.
    localparam int BYTES_PER_ITEM_DEF = 8;
    localparam int MAX_LANES          = 8;
    localparam int DATA_W             = 64;
    localparam int COUNT_W            = 4;
    localparam int IN_TDATA_W         = 72;
    localparam int CHECKSUM_W         = 32;
    localparam int HALF_W             = 16;

    // Widths of the per-item byte sum and weighted byte sum at the largest lane count.
    localparam int BYTE_W   = 8;
    localparam int WPROD_W  = 12;
    localparam int SUM_W    = 11;
    localparam int WSUM_W   = 14;
    localparam int BACC_W   = 20;

    localparam logic [HALF_W:0]     ADLER_MOD   = 17'd65521;
    localparam logic [CHECKSUM_W-1:0] SEED_RESET = 32'd1;
    localparam logic [HALF_W-1:0]   SUM_A_RESET = 16'd1;
    localparam logic [HALF_W-1:0]   SUM_B_RESET = 16'd0;

    // Control fields that travel with an item through the pipeline.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               start;
        logic               last;
    } item_ctrl_t;

    // One conditional subtract; valid for any input below twice the modulus.
    function automatic logic [HALF_W-1:0] reduce_a(input logic [HALF_W:0] x);
        logic [HALF_W:0] diff;
        diff = x - ADLER_MOD;
        reduce_a = (x >= ADLER_MOD) ? diff[HALF_W-1:0] : x[HALF_W-1:0];
    endfunction

    // 2^16 is 15 modulo 65521, so the top bits fold down as 15 * hi before a final subtract.
    function automatic logic [HALF_W-1:0] reduce_b(input logic [BACC_W-1:0] x);
        logic [3:0]      hi;
        logic [7:0]      hi_x15;
        logic [HALF_W:0] folded;
        hi     = x[BACC_W-1:HALF_W];
        hi_x15 = {hi, 4'b0000} - {4'b0000, hi};
        folded = {1'b0, x[HALF_W-1:0]} + {9'd0, hi_x15};
        reduce_b = reduce_a(folded);
    endfunction

endpackage

// File: rtl/adler_lane.sv
// One byte lane: masks its byte by the valid count and weights it for sum B.
`timescale 1ns / 1ps

module adler_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic [adler_pkg::BYTE_W-1:0]  data_byte,
    input  logic [adler_pkg::COUNT_W-1:0] count,
    output logic [adler_pkg::BYTE_W-1:0]  byte_term,
    output logic [adler_pkg::WPROD_W-1:0] weighted_term
);
    import adler_pkg::*;

    logic                lane_valid;
    logic [COUNT_W-1:0]  weight;

    // A byte at position j feeds sum B once for itself and each later valid byte.
    assign lane_valid    = count > COUNT_W'(LANE_IDX);
    assign weight        = count - COUNT_W'(LANE_IDX);
    assign byte_term     = lane_valid ? data_byte : '0;
    assign weighted_term = lane_valid ? (WPROD_W'(weight) * WPROD_W'(data_byte)) : '0;

endmodule

// File: rtl/adler_merge.sv
// Merging stage: adds the lane terms and registers them with the item control fields.
`timescale 1ns / 1ps

module adler_merge #(
    parameter int BYTES_PER_ITEM = adler_pkg::BYTES_PER_ITEM_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           load,
    input  logic                                           advance,
    input  adler_pkg::item_ctrl_t                          ctrl_in,
    input  logic [BYTES_PER_ITEM-1:0][adler_pkg::BYTE_W-1:0]  byte_terms,
    input  logic [BYTES_PER_ITEM-1:0][adler_pkg::WPROD_W-1:0] weighted_terms,
    output logic                                           valid,
    output adler_pkg::item_ctrl_t                          ctrl_out,
    output logic [adler_pkg::SUM_W-1:0]                    byte_sum,
    output logic [adler_pkg::WSUM_W-1:0]                   weighted_sum
);
    import adler_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    item_ctrl_t         ctrl_reg;
    logic [SUM_W-1:0]   byte_sum_reg;
    logic [SUM_W-1:0]   byte_sum_next;
    logic [WSUM_W-1:0]  weighted_sum_reg;
    logic [WSUM_W-1:0]  weighted_sum_next;

    // Sum the independent lane terms.
    always_comb
    begin
        byte_sum_next     = '0;
        weighted_sum_next = '0;
        for (int j = 0; j < BYTES_PER_ITEM; j++)
        begin
            byte_sum_next     = byte_sum_next + SUM_W'(byte_terms[j]);
            weighted_sum_next = weighted_sum_next + WSUM_W'(weighted_terms[j]);
        end
    end

    // The stage fills on a new beat and empties when the accumulator takes it.
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctrl_reg         <= ctrl_in;
            byte_sum_reg     <= byte_sum_next;
            weighted_sum_reg <= weighted_sum_next;
        end
    end

    assign valid        = valid_reg;
    assign ctrl_out     = ctrl_reg;
    assign byte_sum     = byte_sum_reg;
    assign weighted_sum = weighted_sum_reg;

endmodule

// File: rtl/adler_acc.sv
// Running sums A and B with a modular update on each accepted beat, and the result register.
`timescale 1ns / 1ps

module adler_sums (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 fire,
    input  adler_pkg::item_ctrl_t                ctrl,
    input  logic [adler_pkg::SUM_W-1:0]          byte_sum,
    input  logic [adler_pkg::WSUM_W-1:0]         weighted_sum,
    input  logic [adler_pkg::CHECKSUM_W-1:0]     seed,
    output logic                                 ready,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [adler_pkg::CHECKSUM_W-1:0]     checksum
);
    import adler_pkg::*;

    logic [HALF_W-1:0]     sum_a_reg;
    logic [HALF_W-1:0]     sum_a_next;
    logic [HALF_W-1:0]     sum_b_reg;
    logic [HALF_W-1:0]     sum_b_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CHECKSUM_W-1:0] checksum_reg;
    logic [HALF_W-1:0]     a_base;
    logic [HALF_W-1:0]     b_base;
    logic [BACC_W-1:0]     a_times_n;
    logic [BACC_W-1:0]     b_total;

    // Start of a message reloads from the seed; otherwise continue the running sums.
    assign a_base = ctrl.start ? seed[HALF_W-1:0] : sum_a_reg;
    assign b_base = ctrl.start ? seed[CHECKSUM_W-1:HALF_W] : sum_b_reg;

    // A gains the byte sum; B gains n copies of the old A plus the weighted byte sum.
    assign a_times_n  = BACC_W'(a_base) * BACC_W'(ctrl.count);
    assign b_total    = BACC_W'(b_base) + a_times_n + BACC_W'(weighted_sum);
    assign sum_a_next = reduce_a({1'b0, a_base} + (HALF_W+1)'(byte_sum));
    assign sum_b_next = reduce_b(b_total);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg <= SUM_A_RESET;
            sum_b_reg <= SUM_B_RESET;
        end
        else if (fire)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // A last beat may only enter when the result register is free or draining.
    assign ready = !ctrl.last || !out_valid_reg || out_ready;

    always_comb
    begin
        if (fire && ctrl.last)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && ctrl.last)
            checksum_reg <= {sum_b_next, sum_a_next};
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;

endmodule

// File: rtl/adler32_checksum.sv
// Top level of the streaming Adler-32 checksum engine.
`timescale 1ns / 1ps

// Adler-32 over a byte stream, up to BYTES_PER_ITEM bytes per input beat (first byte in the
// low bits). The engine takes one beat per clock cycle while it is not stalled: byte lanes and
// a merging adder register the beat's byte sum and weighted byte sum, and the accumulator then
// updates sums A and B modulo 65521 and registers a finished checksum on the output (two
// register stages from input to output). The sustained rate is one beat per cycle, set by the
// accumulator's feedback loop; it falls only while a finished checksum waits on the output and
// the next beat to reach the accumulator also ends a message. A beat with the start flag set
// begins from the seed register (bits 31:16 sum B, bits 15:0 sum A); a beat with tlast set
// produces one output beat carrying B in bits 31:16 and A in bits 15:0. Write the seed only
// while no message is in flight.
module adler32_checksum #(
    parameter int BYTES_PER_ITEM = adler_pkg::BYTES_PER_ITEM_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [adler_pkg::IN_TDATA_W-1:0]     s_tdata,  // data_bytes [63:0], byte_count [67:64]
    input  logic                                 s_tuser,  // start_flag
    input  logic                                 s_tlast,  // last_flag
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [adler_pkg::CHECKSUM_W-1:0]     m_tdata,  // checksum [31:0]
    output logic                                 m_tlast,  // result_last
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [adler_pkg::CHECKSUM_W-1:0]     cfg_data
);
    import adler_pkg::*;

    logic [CHECKSUM_W-1:0]                    seed_reg;
    logic [COUNT_W-1:0]                       count_raw;
    logic [COUNT_W-1:0]                       count_sat;
    item_ctrl_t                               in_ctrl;
    logic [BYTES_PER_ITEM-1:0][BYTE_W-1:0]    byte_terms;
    logic [BYTES_PER_ITEM-1:0][WPROD_W-1:0]   weighted_terms;
    logic                                     s1_valid;
    item_ctrl_t                               s1_ctrl;
    logic [SUM_W-1:0]                         s1_byte_sum;
    logic [WSUM_W-1:0]                        s1_weighted_sum;
    logic                                     acc_ready;
    logic                                     acc_fire;
    logic                                     in_fire;

    // Seed register, always ready for a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= SEED_RESET;
        else if (cfg_valid && cfg_ready)
            seed_reg <= cfg_data;
    end

    // Counts above the lane count clamp to a full beat.
    assign count_raw = s_tdata[DATA_W +: COUNT_W];
    assign count_sat = (count_raw > COUNT_W'(BYTES_PER_ITEM)) ?
                       COUNT_W'(BYTES_PER_ITEM) : count_raw;

    assign in_ctrl.count = count_sat;
    assign in_ctrl.start = s_tuser;
    assign in_ctrl.last  = s_tlast;

    // One lane per byte position.
    for (genvar j = 0; j < BYTES_PER_ITEM; j++)
    begin : g_lane
        adler_lane #(
            .LANE_IDX (j)
        ) u_lane (
            .data_byte     (s_tdata[BYTE_W*j +: BYTE_W]),
            .count         (count_sat),
            .byte_term     (byte_terms[j]),
            .weighted_term (weighted_terms[j])
        );
    end

    // Handshake between the input, merging stage and accumulator.
    assign acc_fire = s1_valid && acc_ready;
    assign s_tready = !s1_valid || acc_ready;
    assign in_fire  = s_tvalid && s_tready;

    adler_merge #(
        .BYTES_PER_ITEM (BYTES_PER_ITEM)
    ) u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (in_fire),
        .advance        (acc_fire),
        .ctrl_in        (in_ctrl),
        .byte_terms     (byte_terms),
        .weighted_terms (weighted_terms),
        .valid          (s1_valid),
        .ctrl_out       (s1_ctrl),
        .byte_sum       (s1_byte_sum),
        .weighted_sum   (s1_weighted_sum)
    );

    adler_sums u_sums (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (acc_fire),
        .ctrl         (s1_ctrl),
        .byte_sum     (s1_byte_sum),
        .weighted_sum (s1_weighted_sum),
        .seed         (seed_reg),
        .ready        (acc_ready),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .checksum     (m_tdata)
    );

    // Every output beat is the single result of its message.
    assign m_tlast = 1'b1;

    // Both halves of a delivered checksum are fully reduced.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[15:0] < ADLER_MOD[HALF_W-1:0]) &&
                      (m_tdata[31:16] < ADLER_MOD[HALF_W-1:0])))
        else $error("checksum half not reduced modulo 65521");

    // A message end taken by the accumulator always shows up on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_fire && s1_ctrl.last) |=> m_tvalid)
        else $error("final beat did not produce a result");

    // A beat held in the merging stage is not dropped while the accumulator stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && !acc_ready) |=> (s1_valid && $stable(s1_byte_sum)))
        else $error("stalled beat lost from merging stage");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the streaming Adler-32 checksum engine.
`timescale 1ns / 1ps

module testbench;

    import adler_pkg::*;

    localparam int          LANES      = 8;
    localparam int unsigned MODULUS    = 65521;
    localparam int          SETTLE     = 8;
    localparam int          HOLD_AT    = 300;
    localparam int          HOLD_LEN   = 250;
    localparam int          RAND_BEATS = 1000;
    localparam int          N_PHASES   = 8;

    // One input beat as the engine sees it.
    typedef struct {
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               start;
        logic               last;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;   // data_bytes [63:0], byte_count [67:64]
    logic                  s_tuser = 1'b0; // start_flag
    logic                  s_tlast = 1'b0; // last_flag
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [CHECKSUM_W-1:0] m_tdata;        // checksum [31:0]
    logic                  m_tlast;        // result_last
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CHECKSUM_W-1:0] cfg_data = '0;

    adler32_checksum #(
        .BYTES_PER_ITEM(LANES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Stimulus and expectation stores, plus the running state of the predictor.
    beat_t                 beat_q[$];
    logic [CHECKSUM_W-1:0] checksum_q[$];
    beat_t                 on_bus;
    logic [CHECKSUM_W-1:0] seed_reg = SEED_RESET;
    logic [HALF_W-1:0]     run_a = SUM_A_RESET;
    logic [HALF_W-1:0]     run_b = SUM_B_RESET;

    int  beats_pending = 0;
    int  beats_taken = 0;
    int  messages = 0;
    int  sums_checked = 0;
    int  seeds_written = 0;
    int  errors = 0;
    bit  quiet_tail = 1'b0;
    bit  hold_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Print one line per mismatch and keep a tally.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
        errors++;
    endtask

    // Fold one beat into the running sums and return the packed checksum after it.
    function automatic logic [CHECKSUM_W-1:0] fold_beat(input beat_t bt);
        int unsigned a;
        int unsigned b;
        int unsigned n;
        int unsigned i;
        if (bt.start)
        begin
            a = seed_reg[15:0];
            b = seed_reg[31:16];
        end
        else
        begin
            a = run_a;
            b = run_b;
        end
        n = (bt.count > LANES) ? LANES : bt.count;
        for (i = 0; i < n; i++)
        begin
            a = (a + bt.data[8*i +: 8]) % MODULUS;
            b = (b + a) % MODULUS;
        end
        a = a % MODULUS;
        b = b % MODULUS;
        run_a = a[15:0];
        run_b = b[15:0];
        return {run_b, run_a};
    endfunction

    task automatic push_beat(input logic [DATA_W-1:0] data, input int count,
                             input bit start, input bit last);
        beat_t bt;
        bt.data  = data;
        bt.count = count[COUNT_W-1:0];
        bt.start = start;
        bt.last  = last;
        beat_q.push_back(bt);
        beats_pending++;
        if (last)
            messages++;
    endtask

    function automatic logic [DATA_W-1:0] random_data();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Byte counts are mostly in range; zero and oversized counts turn up now and then.
    function automatic int random_count();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return $urandom_range(LANES + 1, 15);
            default: return $urandom_range(1, LANES);
        endcase
    endfunction

    // A message of n beats; broken ones get random start and last flags.
    task automatic queue_message(input int n, input bit well_formed);
        int k;
        for (k = 0; k < n; k++)
        begin
            if (well_formed)
                push_beat(random_data(), random_count(), k == 0, k == n - 1);
            else
                push_beat(random_data(), random_count(), $urandom_range(0, 3) == 0,
                          $urandom_range(0, 3) == 0);
        end
    endtask

    // Wait until every beat is taken and every checksum is back, then let the pipeline empty.
    task automatic drain_pipeline();
        int guard;
        guard = 0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while ((beats_pending != 0 || checksum_q.size() != 0) && guard < 20000);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_seed(input logic [CHECKSUM_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        seed_reg = value;
        seeds_written++;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Driver: offers queued beats, records each accepted beat in the predictor.
    always @(posedge clk)
    begin : drive_input
        static int gap_left = 0;
        logic      valid_next;
        logic [CHECKSUM_W-1:0] sum;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sum = fold_beat(on_bus);
                if (on_bus.last)
                    checksum_q.push_back(sum);
                beats_pending--;
                beats_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                valid_next = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (beat_q.size() != 0)
                begin
                    on_bus = beat_q.pop_front();
                    s_tdata <= {{(IN_TDATA_W - DATA_W - COUNT_W){1'b0}}, on_bus.count,
                                on_bus.data};
                    s_tuser <= on_bus.start;
                    s_tlast <= on_bus.last;
                    valid_next = 1'b1;
                    if (!quiet_tail && $urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(1, 5);
                end
                s_tvalid <= valid_next;
            end
        end
    end

    // Monitor: checks each output beat against the oldest expected checksum.
    always @(posedge clk)
    begin : watch_output
        static int stall_left = 0;
        static int hold_left = 0;
        logic      ready_next;
        logic [CHECKSUM_W-1:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (checksum_q.size() == 0)
                    report_mismatch("unexpected checksum beat", m_tdata, '0);
                else
                begin
                    want = checksum_q.pop_front();
                    sums_checked++;
                    if (m_tdata !== want)
                        report_mismatch("checksum", m_tdata, want);
                    if (m_tlast !== 1'b1)
                        report_mismatch("result_last", {31'd0, m_tlast}, 32'd1);
                end
            end
            // One long hold-off part way through, so the engine backs up onto its input.
            if (!hold_done && beats_taken >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            ready_next = 1'b1;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 5);
            m_tready <= ready_next;
        end
    end

    // Overall time limit.
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Main sequence: reset, directed beats, then random phases with fresh seeds.
    initial
    begin : main_flow
        int p;
        int target;
        int guard;
        logic [CHECKSUM_W-1:0] seed;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset sums without a start flag, then full, empty and oversized counts.
        push_beat(64'h0000_0000_0063_6261, 3, 1'b0, 1'b1);
        push_beat('1, 8, 1'b1, 1'b1);
        push_beat(random_data(), 0, 1'b1, 1'b1);
        push_beat(random_data(), 15, 1'b1, 1'b1);
        push_beat(random_data(), 9, 1'b1, 1'b0);
        push_beat(random_data(), 12, 1'b0, 1'b1);
        drain_pipeline();

        // Seed halves above the modulus, both on an empty beat and with bytes.
        write_seed(32'hFFFF_FFFF);
        push_beat(random_data(), 0, 1'b1, 1'b1);
        push_beat(64'h0000_0000_0000_00FF, 1, 1'b1, 1'b1);
        push_beat('0, 8, 1'b0, 1'b1);
        drain_pipeline();

        write_seed(32'h0000_0000);
        push_beat('0, 8, 1'b1, 1'b1);
        push_beat(random_data(), 4, 1'b1, 1'b1);
        drain_pipeline();

        // Seed halves just below the modulus, with the largest bytes.
        write_seed(32'hFFF0_FFF0);
        push_beat('1, 8, 1'b1, 1'b1);
        push_beat('1, 10, 1'b1, 1'b0);
        push_beat('1, 8, 1'b0, 1'b1);
        drain_pipeline();

        write_seed(32'hFFF1_FFF1);
        push_beat(random_data(), 0, 1'b1, 1'b1);
        push_beat(random_data(), 2, 1'b1, 1'b1);
        drain_pipeline();

        // Random phases: mostly well-formed messages, some broken sequences.
        for (p = 0; p < N_PHASES; p++)
        begin
            case (p % 4)
                0:       seed = SEED_RESET;
                1:       seed = {$urandom};
                2:       seed = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
                default: seed = {$urandom};
            endcase
            write_seed(seed);
            if (p == N_PHASES - 1)
                quiet_tail = 1'b1;
            target = beats_taken + beats_pending + RAND_BEATS / N_PHASES;
            while (beats_taken + beats_pending < target)
                queue_message($urandom_range(1, 12), $urandom_range(0, 4) != 0);
            drain_pipeline();
        end

        // Allow any stray output beat to show up before the verdict.
        guard = 0;
        while (checksum_q.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        while (checksum_q.size() != 0)
        begin
            void'(checksum_q.pop_front());
            report_mismatch("checksum never arrived", '0, '0);
        end

        $display("Run covered %0d beats in %0d messages under %0d seed writes.",
                 beats_taken, messages, seeds_written);
        $display("%0d checksums compared, including a %0d-cycle output hold-off.",
                 sums_checked, HOLD_LEN);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
